/* rtl/lws_pkg.sv */
package lws_pkg;

  localparam int MAX_ENTRIES = 32;

  localparam int ID_W   = 8;
  localparam int TK_W   = 16;
  localparam int DRAW_W = 32;

  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int TOT_W  = $clog2(MAX_ENTRIES * ((2 ** TK_W) - 1) + 1);
  localparam int ENT_W  = ID_W + TK_W;
  localparam int KEY_W  = TK_W + ID_W + IDX_W;
  localparam int STEP_W = $clog2(DRAW_W + 1);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_MOD,
    ST_SCAN,
    ST_STEP,
    ST_DONE
  } lws_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lws_mod_stat_t;

  // Walk order key: ascending tickets, then descending id, then slot index.
  // The index only separates identical entries, which give the same answer.
  function automatic logic [KEY_W-1:0] walk_key(input logic [TK_W-1:0]  tk,
                                                input logic [ID_W-1:0]  id,
                                                input logic [IDX_W-1:0] idx);
    walk_key = {tk, ~id, idx};
  endfunction

endpackage

/* rtl/lws_ram.sv */
module lws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic                             rd_en,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/lws_mod.sv */
module lws_mod (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [lws_pkg::DRAW_W-1:0]   dividend,
  input  logic [lws_pkg::TOT_W-1:0]    divisor,
  output lws_pkg::lws_mod_stat_t       stat,
  output logic [lws_pkg::TOT_W-1:0]    remainder
);

  import lws_pkg::*;

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step_cnt;
  logic [DRAW_W-1:0] bits;
  logic [TOT_W-1:0]  rem;
  logic [TOT_W-1:0]  rem_next;
  logic [TOT_W:0]    rem_shift;
  logic [TOT_W:0]    trial;

  // One quotient bit per cycle, restoring form; the top bit of the trial
  // difference is the borrow.
  always_comb begin
    rem_shift = {rem, bits[DRAW_W-1]};
    trial     = rem_shift - {1'b0, divisor};
    rem_next  = trial[TOT_W] ? rem_shift[TOT_W-1:0] : trial[TOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step_cnt <= STEP_W'(DRAW_W);
      end else if (busy) begin
        step_cnt <= step_cnt - STEP_W'(1);
        if (step_cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bits <= dividend;
      rem  <= '0;
    end else if (busy) begin
      bits <= bits << 1;
      rem  <= rem_next;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign remainder = rem;

endmodule

/* rtl/lottery_winner_select_core.sv */
// Channel | Direction | Handshake                  | Beat contents
// item    | in        | item_valid / item_stall    | proc_id, tickets, is_user, draw, last
// result  | out       | result_valid / result_stall| winner_id, no_tickets, overflowed
//
// Entries load at one beat per cycle while item_stall is low. If the list
// holds any tickets, the draw is then reduced by a bit-serial remainder unit
// and the entries are walked in ticket order by repeated scans of the entry
// RAM, one entry per pass, until the running ticket sum exceeds the remainder.
// Reset is synchronous and clears the sequencer, counters and result valid.
// A held result does not block loading of the next list; a new result waits.
module lottery_winner_select_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic [lws_pkg::ID_W-1:0]     proc_id,
  input  logic [lws_pkg::TK_W-1:0]     tickets,
  input  logic                         is_user,
  input  logic [lws_pkg::DRAW_W-1:0]   draw,
  input  logic                         last,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [lws_pkg::ID_W-1:0]     winner_id,
  output logic                         no_tickets,
  output logic                         overflowed
);

  import lws_pkg::*;

  lws_state_t    state;
  lws_state_t    state_next;

  logic [CNT_W-1:0] entry_count;
  logic [TOT_W-1:0] ticket_total;
  logic             overflow_seen;

  logic [CNT_W-1:0] list_len;
  logic [TOT_W-1:0] div_total;
  logic             ovf_flag;
  logic             zero_flag;
  logic [ID_W-1:0]  win_id;

  logic             accept;
  logic             keep;
  logic [CNT_W-1:0] count_upd;
  logic [TOT_W-1:0] total_upd;
  logic             ovf_upd;

  logic             div_start;
  lws_mod_stat_t    div_stat;
  logic [TOT_W-1:0] remainder;

  logic [CNT_W-1:0] scan_idx;
  logic             scan_issue;
  logic             rd_pend;
  logic [IDX_W-1:0] rd_idx;
  logic [ENT_W-1:0] rd_data;
  logic [KEY_W-1:0] cand_key;
  logic             cand_take;

  logic             found;
  logic             have_prev;
  logic [KEY_W-1:0] best_key;
  logic [KEY_W-1:0] prev_key;
  logic [TK_W-1:0]  best_tk;
  logic [ID_W-1:0]  best_id;
  logic [TOT_W-1:0] sum;
  logic [TOT_W-1:0] sum_next;
  logic             hit;
  logic             out_load;

  // Entry store: {id, tickets} per slot.
  lws_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_ENTRIES)
  ) u_entries (
    .clk     (clk),
    .wr_en   (keep),
    .wr_addr (entry_count[IDX_W-1:0]),
    .wr_data ({proc_id, tickets}),
    .rd_en   (scan_issue),
    .rd_addr (scan_idx[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // The remainder unit takes the draw straight from the last beat.
  lws_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (draw),
    .divisor   (div_total),
    .stat      (div_stat),
    .remainder (remainder)
  );

  always_comb begin
    accept    = item_valid && !item_stall;
    keep      = accept && is_user && (entry_count < CNT_W'(MAX_ENTRIES));
    count_upd = keep ? entry_count + CNT_W'(1) : entry_count;
    total_upd = keep ? ticket_total + TOT_W'(tickets) : ticket_total;
    ovf_upd   = overflow_seen | (accept && is_user && !keep);

    cand_key  = walk_key(rd_data[TK_W-1:0], rd_data[ENT_W-1:TK_W], rd_idx);
    cand_take = rd_pend && (!have_prev || (cand_key > prev_key)) &&
                (!found || (cand_key < best_key));

    sum_next  = sum + TOT_W'(best_tk);
    hit       = found && (sum_next > remainder);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (accept && last) begin
          state_next = (total_upd == '0) ? ST_DONE : ST_MOD;
        end
      end
      ST_MOD: begin
        if (div_stat.done) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ((scan_idx == list_len) && !rd_pend) begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        state_next = (hit || !found) ? ST_DONE : ST_SCAN;
      end
      ST_DONE: begin
        if (!result_valid || !result_stall) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    item_stall = 1'b1;
    div_start  = 1'b0;
    scan_issue = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_LOAD: begin
        item_stall = 1'b0;
        div_start  = accept && last && (total_upd != '0);
      end
      ST_SCAN: scan_issue = (scan_idx < list_len);
      ST_DONE: out_load   = !result_valid || !result_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      entry_count   <= '0;
      ticket_total  <= '0;
      overflow_seen <= 1'b0;
      rd_pend       <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= scan_issue;
      if (accept) begin
        if (last) begin
          entry_count   <= '0;
          ticket_total  <= '0;
          overflow_seen <= 1'b0;
        end else begin
          entry_count   <= count_upd;
          ticket_total  <= total_upd;
          overflow_seen <= ovf_upd;
        end
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Walk datapath: each pass finds the smallest key above the previous one.
  always_ff @(posedge clk) begin
    if (accept && last) begin
      list_len  <= count_upd;
      div_total <= total_upd;
      ovf_flag  <= ovf_upd;
      zero_flag <= (total_upd == '0);
      win_id    <= '0;
    end
    if (state == ST_MOD) begin
      scan_idx  <= '0;
      found     <= 1'b0;
      have_prev <= 1'b0;
      sum       <= '0;
    end
    if (scan_issue) begin
      scan_idx <= scan_idx + CNT_W'(1);
      rd_idx   <= scan_idx[IDX_W-1:0];
    end
    if ((state == ST_SCAN) && cand_take) begin
      found    <= 1'b1;
      best_key <= cand_key;
      best_tk  <= rd_data[TK_W-1:0];
      best_id  <= rd_data[ENT_W-1:TK_W];
    end
    if (state == ST_STEP) begin
      if (hit) begin
        win_id <= best_id;
      end else if (found) begin
        sum       <= sum_next;
        prev_key  <= best_key;
        have_prev <= 1'b1;
        found     <= 1'b0;
        scan_idx  <= '0;
      end
    end
    if (out_load) begin
      winner_id  <= win_id;
      no_tickets <= zero_flag;
      overflowed <= ovf_flag;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above capacity");

  // The running sum reaches the total, which always exceeds the remainder.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP) |-> found)
    else $error("ordered walk ran out of entries");

  assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == ST_MOD))
    else $error("remainder unit finished outside its phase");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOD) |-> (div_stat.busy || div_stat.done))
    else $error("remainder unit idle during its phase");

  assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (state == ST_SCAN))
    else $error("entry read returned outside a scan");

endmodule

/* tb/lottery_winner_select_core_tb.sv */
module lottery_winner_select_core_tb;

  import lws_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int BEATS_PER_PHASE = 275;

  // Keeps the ready list as the block should see it and queues the winner each
  // list is due to produce.
  class lottery_ledger;
    typedef struct {
      logic [ID_W-1:0] winner_id;
      logic            no_tickets;
      logic            overflowed;
    } pick_t;

    logic [ID_W-1:0] kept_ids[$];
    logic [TK_W-1:0] kept_tks[$];
    logic [31:0]     ticket_sum;
    logic            dropped;
    pick_t           pending_picks[$];
    int              errors;
    int              winners_checked;

    function new();
      ticket_sum = 0;
      dropped = 1'b0;
      errors = 0;
      winners_checked = 0;
    endfunction

    // Walk order: fewer tickets first, and the higher id first when tickets tie.
    function logic [ID_W-1:0] draw_winner(input logic [31:0] draw_val);
      logic [ID_W-1:0] ids[$];
      logic [TK_W-1:0] tks[$];
      logic [31:0]     target;
      logic [31:0]     running;
      int              k;
      ids = {};
      tks = {};
      foreach (kept_ids[i]) begin
        k = 0;
        while (k < ids.size() && !(kept_tks[i] < tks[k] ||
               (kept_tks[i] == tks[k] && kept_ids[i] > ids[k])))
          k++;
        ids.insert(k, kept_ids[i]);
        tks.insert(k, kept_tks[i]);
      end
      target = draw_val % ticket_sum;
      running = 0;
      foreach (tks[j]) begin
        running += 32'(tks[j]);
        if (running > target)
          return ids[j];
      end
      return '0;
    endfunction

    function void take_entry(input logic [ID_W-1:0] id, input logic [TK_W-1:0] tk,
                             input logic user, input logic [DRAW_W-1:0] draw_val,
                             input logic lst);
      pick_t p;
      if (user) begin
        if (kept_ids.size() < MAX_ENTRIES) begin
          kept_ids.push_back(id);
          kept_tks.push_back(tk);
          ticket_sum += 32'(tk);
        end else begin
          dropped = 1'b1;
        end
      end
      if (lst) begin
        if (ticket_sum == 0) begin
          p.winner_id = '0;
          p.no_tickets = 1'b1;
        end else begin
          p.winner_id = draw_winner(draw_val);
          p.no_tickets = 1'b0;
        end
        p.overflowed = dropped;
        pending_picks.push_back(p);
        kept_ids.delete();
        kept_tks.delete();
        ticket_sum = 0;
        dropped = 1'b0;
      end
    endfunction

    function void match_winner(input logic [ID_W-1:0] w, input logic nt, input logic of);
      pick_t p;
      if (pending_picks.size() == 0) begin
        $error("result beat with no winner pending: winner_id %0d", w);
        errors++;
        return;
      end
      p = pending_picks.pop_front();
      winners_checked++;
      if (w !== p.winner_id) begin
        $error("winner_id: expected %0d, got %0d", p.winner_id, w);
        errors++;
      end
      if (nt !== p.no_tickets) begin
        $error("no_tickets: expected %0d, got %0d", p.no_tickets, nt);
        errors++;
      end
      if (of !== p.overflowed) begin
        $error("overflowed: expected %0d, got %0d", p.overflowed, of);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              item_valid;
  logic              item_stall;
  logic [ID_W-1:0]   proc_id;
  logic [TK_W-1:0]   tickets;
  logic              is_user;
  logic [DRAW_W-1:0] draw;
  logic              last;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic [ID_W-1:0]   winner_id;
  logic              no_tickets;
  logic              overflowed;

  lottery_ledger ledger = new();

  int          idle_pct;
  int          stall_pct;
  int          long_hold;
  int          beats_sent;
  int          lists_sent;
  int unsigned cycle_count;

  lottery_winner_select_core u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .proc_id      (proc_id),
    .tickets      (tickets),
    .is_user      (is_user),
    .draw         (draw),
    .last         (last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .winner_id    (winner_id),
    .no_tickets   (no_tickets),
    .overflowed   (overflowed)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: check each accepted beat, then decide the stall for the next cycle.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall)
        ledger.match_winner(winner_id, no_tickets, overflowed);
      if (long_hold > 0) begin
        result_stall <= 1'b1;
        long_hold--;
      end else begin
        result_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_entry(input logic [ID_W-1:0] id, input logic [TK_W-1:0] tk,
                            input logic user, input logic [DRAW_W-1:0] draw_val,
                            input logic lst);
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    proc_id <= id;
    tickets <= tk;
    is_user <= user;
    draw <= draw_val;
    last <= lst;
    @(posedge clk);
    while (item_stall)
      @(posedge clk);
    ledger.take_entry(id, tk, user, draw_val, lst);
    beats_sent++;
    if (lst)
      lists_sent++;
  endtask

  task automatic wait_for_winners();
    item_valid <= 1'b0;
    @(posedge clk);
    while (ledger.pending_picks.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    int              phase_idle[4];
    int              phase_stall[4];
    int              target;
    int              list_len;
    int              lists_in_phase;
    bit              all_user;
    logic [ID_W-1:0] id;
    logic [TK_W-1:0] tk;
    logic [DRAW_W-1:0] dv;
    phase_idle = '{0, 87, 0, 35};
    phase_stall = '{0, 0, 87, 35};
    rst = 1'b1;
    item_valid = 1'b0;
    proc_id = '0;
    tickets = '0;
    is_user = 1'b0;
    draw = '0;
    last = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    long_hold = 0;
    beats_sent = 0;
    lists_sent = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A list with no user entry at all, then a lone entry holding no tickets.
    send_entry(8'h00, 16'h0000, 1'b0, 32'h0000_0000, 1'b1);
    send_entry(8'hFF, 16'h0000, 1'b1, 32'hFFFF_FFFF, 1'b1);
    send_entry(8'hFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 1'b1);
    // Equal tickets must put the higher id first; the closing beat is not a user entry.
    send_entry(8'd10, 16'd5, 1'b1, 32'hFFFF_FFFF, 1'b0);
    send_entry(8'd20, 16'd5, 1'b1, 32'hFFFF_FFFF, 1'b0);
    send_entry(8'd0, 16'd0, 1'b1, 32'hFFFF_FFFF, 1'b0);
    send_entry(8'd77, 16'd9, 1'b0, 32'h0000_0000, 1'b1);
    send_entry(8'd10, 16'd5, 1'b1, 32'h0, 1'b0);
    send_entry(8'd20, 16'd5, 1'b1, 32'h0, 1'b0);
    send_entry(8'd0, 16'd0, 1'b1, 32'd5, 1'b1);
    // A total wider than the ticket field.
    send_entry(8'h00, 16'hFFFF, 1'b1, 32'h0, 1'b0);
    send_entry(8'hFF, 16'hFFFF, 1'b1, 32'h0, 1'b0);
    send_entry(8'h80, 16'h0001, 1'b1, 32'hFFFF_FFFF, 1'b1);
    send_entry(8'h55, 16'd3, 1'b1, 32'h0, 1'b0);
    send_entry(8'h55, 16'd3, 1'b1, 32'hAAAA_AAAA, 1'b1);
    send_entry(8'd1, 16'd100, 1'b0, 32'h0, 1'b0);
    send_entry(8'd2, 16'd0, 1'b1, 32'h0, 1'b0);
    send_entry(8'd3, 16'd7, 1'b1, 32'h8000_0000, 1'b1);
    wait_for_winners();

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = phase_idle[phase];
      stall_pct = phase_stall[phase];
      target = beats_sent + BEATS_PER_PHASE;
      lists_in_phase = 0;
      while (beats_sent < target) begin
        // Each phase opens with a list of user entries around the capacity.
        all_user = (lists_in_phase == 0);
        if (all_user) begin
          list_len = MAX_ENTRIES - 1 + phase;
        end else begin
          case ($urandom_range(99)) inside
            [0:2]:   list_len = $urandom_range(MAX_ENTRIES + 10, MAX_ENTRIES - 2);
            [3:17]:  list_len = $urandom_range(16, 7);
            default: list_len = $urandom_range(6, 1);
          endcase
        end
        // The result side holds off long enough for the block to back up.
        if (phase == 0 && lists_in_phase == 8)
          long_hold = 2500;
        for (int e = 0; e < list_len; e++) begin
          if ($urandom_range(9) < 3)
            id = ID_W'($urandom_range(3));
          else
            id = ID_W'($urandom_range(255));
          case ($urandom_range(9))
            0:       tk = 16'h0000;
            1:       tk = 16'hFFFF;
            2, 3, 4: tk = TK_W'($urandom_range(15));
            default: tk = TK_W'($urandom_range(65535));
          endcase
          case ($urandom_range(9))
            0:       dv = DRAW_W'($urandom_range(31));
            1:       dv = 32'hFFFF_FFFF;
            default: dv = $urandom;
          endcase
          send_entry(id, tk, all_user || ($urandom_range(99) < 85), dv,
                     e == list_len - 1);
        end
        lists_in_phase++;
      end
      wait_for_winners();
    end

    idle_pct = 0;
    stall_pct = 0;
    repeat (1200) @(posedge clk);
    $display("Ran %0d ready lists in %0d entry beats over four idling phases and a long hold-off.",
             lists_sent, beats_sent);
    $display("Checked %0d winners, %0d mismatches.", ledger.winners_checked, ledger.errors);
    if (ledger.errors == 0 && ledger.pending_picks.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
